// ===== rtl/csms_pkg.sv =====
// Shared types and constants for the conservative span mark/sweep block.
// No dependencies; imported by every module under rtl/.
`timescale 1ns / 1ps

package csms_pkg;

    localparam int ADDR_W  = 64;
    localparam int SIZE_W  = 17;
    localparam int OBJS_W  = 32;
    localparam int PROD_W  = 2 * SIZE_W;

    localparam logic [63:0] WARN_THR_RESET = 64'd3006477107;
    localparam logic [63:0] CRIT_THR_RESET = 64'd3865470566;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_MARK  = 2'd2,
        OP_SWEEP = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_LEAK  = 2'd0,
        KIND_CRIT  = 2'd1,
        KIND_CLEAN = 2'd2,
        KIND_FULL  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CFG_SCAN_EN  = 2'd0,
        CFG_WARN_THR = 2'd1,
        CFG_CRIT_THR = 2'd2,
        CFG_UNUSED   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        SW_IDLE,
        SW_SCAN,
        SW_DRAIN,
        SW_FINAL,
        SW_SUM
    } t_sweep_state;

    // One table entry as it travels along the chain
    typedef struct packed {
        logic              valid;
        logic              mark;
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] stride;
        logic [SIZE_W-1:0] in_use;
    } t_span;

    typedef struct packed {
        logic shift;
        logic mark;
        logic clear;
    } t_cell_ctrl;

    typedef struct packed {
        logic              valid;
        logic              last;
        t_kind             kind;
        logic [ADDR_W-1:0] base;
        logic [63:0]       bytes;
        logic [OBJS_W-1:0] objs;
    } t_result;

endpackage

// ===== rtl/csms_cell.sv =====
// One slot of the span chain: holds an entry, matches candidate words
// against it and passes its entry to the next slot on shift. Uses csms_pkg.
`timescale 1ns / 1ps

module csms_cell
    import csms_pkg::*;
#(
    parameter int SPAN_RANGE = 65536
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  logic [ADDR_W-1:0] i_word,
    input  t_span      i_prev,
    output t_span      o_span
);

    logic              r_valid;
    logic              r_mark;
    logic [ADDR_W-1:0] r_base;
    logic [SIZE_W-1:0] r_stride;
    logic [SIZE_W-1:0] r_in_use;
    logic [ADDR_W-1:0] w_off;
    logic              w_hit;

    // range ends at 2^64: offset is only meaningful when word >= base
    assign w_off = i_word - r_base;
    assign w_hit = r_valid && (i_word != '0) && (i_word >= r_base)
                   && (w_off < ADDR_W'(SPAN_RANGE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_mark  <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_valid <= 1'b0;
            r_mark  <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_valid <= i_prev.valid;
            r_mark  <= i_prev.mark;
        end else if (i_ctrl.mark && w_hit) begin
            r_mark  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_base   <= i_prev.base;
            r_stride <= i_prev.stride;
            r_in_use <= i_prev.in_use;
        end
    end

    assign o_span = '{valid: r_valid, mark: r_mark, base: r_base,
                      stride: r_stride, in_use: r_in_use};

endmodule

// ===== rtl/csms_sweep.sv =====
// Sweep sequencer: rotates the chain once, picks leak candidates off the
// tail slot and emits them; at critical level a summary closes the sweep. Uses csms_pkg.
`timescale 1ns / 1ps

module csms_sweep
    import csms_pkg::*;
#(
    parameter int SPAN_SLOTS = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_crit,
    input  t_span   i_tail,
    output logic    o_busy,
    output logic    o_rotate,
    output t_result o_res
);

    localparam int CNT_W = (SPAN_SLOTS > 1) ? $clog2(SPAN_SLOTS) : 1;
    localparam int NL_W  = $clog2(SPAN_SLOTS + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SPAN_SLOTS - 1);

    t_sweep_state r_state, n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_crit;
    // stage 1: candidate picked off the tail
    logic              r_c_vld;
    logic [ADDR_W-1:0] r_c_base;
    logic [SIZE_W-1:0] r_c_stride;
    logic [SIZE_W-1:0] r_c_in_use;
    // stage 2: pending candidate, held until we know whether it is last
    logic              r_p_vld;
    logic [ADDR_W-1:0] r_p_base;
    logic [63:0]       r_p_bytes;
    logic [SIZE_W-1:0] r_p_objs;
    logic [63:0]       r_total;
    logic [NL_W-1:0]   r_nleak;

    logic              w_cand;
    logic              w_scan;
    logic              w_move;
    logic [PROD_W-1:0] w_prod;

    assign w_cand = i_tail.valid && !i_tail.mark && (i_tail.in_use != '0);
    assign w_scan = (r_state == SW_SCAN);
    assign w_move = (r_state == SW_SCAN) || (r_state == SW_DRAIN);
    assign w_prod = PROD_W'(r_c_stride) * PROD_W'(r_c_in_use);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SW_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_rotate = 1'b0;
        o_res    = '0;
        case (r_state)
            SW_IDLE: begin
                if (i_start) n_state = SW_SCAN;
            end
            SW_SCAN: begin
                o_rotate = 1'b1;
                if (r_c_vld && r_p_vld) begin
                    o_res = '{valid: 1'b1, last: 1'b0, kind: KIND_LEAK, base: r_p_base,
                              bytes: r_p_bytes, objs: OBJS_W'(r_p_objs)};
                end
                if (r_cnt == LAST_CNT) n_state = SW_DRAIN;
            end
            SW_DRAIN: begin
                if (r_c_vld && r_p_vld) begin
                    o_res = '{valid: 1'b1, last: 1'b0, kind: KIND_LEAK, base: r_p_base,
                              bytes: r_p_bytes, objs: OBJS_W'(r_p_objs)};
                end
                n_state = SW_FINAL;
            end
            SW_FINAL: begin
                if (r_crit) begin
                    if (r_p_vld) begin
                        o_res = '{valid: 1'b1, last: 1'b0, kind: KIND_LEAK,
                                  base: r_p_base, bytes: r_p_bytes,
                                  objs: OBJS_W'(r_p_objs)};
                    end
                    n_state = SW_SUM;
                end else begin
                    if (r_p_vld) begin
                        o_res = '{valid: 1'b1, last: 1'b1, kind: KIND_LEAK,
                                  base: r_p_base, bytes: r_p_bytes,
                                  objs: OBJS_W'(r_p_objs)};
                    end else begin
                        o_res = '{valid: 1'b1, last: 1'b1, kind: KIND_CLEAN,
                                  base: '0, bytes: '0, objs: '0};
                    end
                    n_state = SW_IDLE;
                end
            end
            SW_SUM: begin
                o_res = '{valid: 1'b1, last: 1'b1, kind: KIND_CRIT, base: '0,
                          bytes: r_total, objs: OBJS_W'(r_nleak)};
                n_state = SW_IDLE;
            end
            default: begin
                n_state = SW_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != SW_IDLE);

    // control of the candidate pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
            r_p_vld <= 1'b0;
            r_cnt   <= '0;
            r_crit  <= 1'b0;
        end else if ((r_state == SW_IDLE) && i_start) begin
            r_c_vld <= 1'b0;
            r_p_vld <= 1'b0;
            r_cnt   <= '0;
            r_crit  <= i_crit;
        end else if (w_move) begin
            r_c_vld <= w_scan && w_cand;
            if (r_c_vld) r_p_vld <= 1'b1;
            if (w_scan) r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == SW_IDLE) && i_start) begin
            r_total <= '0;
            r_nleak <= '0;
        end else if (w_move) begin
            r_c_base   <= i_tail.base;
            r_c_stride <= i_tail.stride;
            r_c_in_use <= i_tail.in_use;
            if (r_c_vld) begin
                r_p_base  <= r_c_base;
                r_p_bytes <= 64'(w_prod);
                r_p_objs  <= r_c_in_use;
                if (r_p_vld) r_total <= r_total + r_p_bytes;
            end
            if (w_scan && w_cand) r_nleak <= r_nleak + NL_W'(1);
        end else if ((r_state == SW_FINAL) && r_p_vld) begin
            r_total <= r_total + r_p_bytes;
        end
    end

endmodule

// ===== rtl/conservative_span_mark_sweep_top.sv =====
// Clear, load and mark never raise busy; a load into a full table strobes its
// result in the cycle after it is taken. A sweep holds busy while the span
// chain rotates one slot per cycle past the sweep unit.
// Results come out registered, one per cycle; the receiver cannot stall.
// Synchronous active-low reset empties the table and restores the registers.
`timescale 1ns / 1ps

module conservative_span_mark_sweep_top
    import csms_pkg::*;
#(
    parameter int SPAN_SLOTS = 32,
    parameter int SPAN_RANGE = 65536
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_opcode,
    input  logic [ADDR_W-1:0] i_span_addr,
    input  logic [SIZE_W-1:0] i_span_stride,
    input  logic [SIZE_W-1:0] i_span_in_use,
    input  logic [ADDR_W-1:0] i_cand_word,
    input  logic [63:0]       i_reserved_bytes,
    input  logic              i_manual_scan,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_data,
    output logic              o_strobe,
    output logic [1:0]        o_kind,
    output logic [ADDR_W-1:0] o_leak_base,
    output logic [63:0]       o_leak_bytes,
    output logic [OBJS_W-1:0] o_leak_objects,
    output logic              o_last
);

    localparam int CW = $clog2(SPAN_SLOTS + 1);

    logic [CW-1:0] r_count;
    logic          r_scan_en;
    logic [63:0]   r_warn_thr;
    logic [63:0]   r_crit_thr;

    logic          r_strobe;
    t_kind         r_kind;
    logic [ADDR_W-1:0] r_base;
    logic [63:0]   r_bytes;
    logic [OBJS_W-1:0] r_objs;
    logic          r_last;

    logic          w_accept, w_full, w_load_ok, w_load_full;
    logic          w_crit, w_warn, w_sweep_go;
    logic          w_rotate, w_busy;
    t_cell_ctrl    w_ctrl;
    t_span         w_new;
    t_span         w_cell [SPAN_SLOTS];
    t_span         w_feed;
    t_result       w_res;
    logic [SPAN_SLOTS-1:0] w_valid_vec;

    assign w_accept    = start && !w_busy;
    assign w_full      = (r_count == CW'(SPAN_SLOTS));
    assign w_load_ok   = w_accept && (i_opcode == OP_LOAD) && !w_full;
    assign w_load_full = w_accept && (i_opcode == OP_LOAD) && w_full;
    assign w_crit      = (i_reserved_bytes >= r_crit_thr);
    assign w_warn      = (i_reserved_bytes >= r_warn_thr) || i_manual_scan;
    assign w_sweep_go  = w_accept && (i_opcode == OP_SWEEP) && r_scan_en
                         && (w_crit || w_warn);

    assign w_ctrl = '{shift: w_load_ok || w_rotate,
                      mark:  w_accept && (i_opcode == OP_MARK),
                      clear: w_accept && (i_opcode == OP_CLEAR)};

    assign w_new  = '{valid: 1'b1, mark: 1'b0, base: i_span_addr,
                      stride: i_span_stride, in_use: i_span_in_use};
    // new spans enter at slot 0; during a sweep the tail wraps back to it
    assign w_feed = w_rotate ? w_cell[SPAN_SLOTS-1] : w_new;

    for (genvar g = 0; g < SPAN_SLOTS; g++) begin : g_cell
        csms_cell #(
            .SPAN_RANGE (SPAN_RANGE)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_word  (i_cand_word),
            .i_prev  ((g == 0) ? w_feed : w_cell[(g == 0) ? 0 : g - 1]),
            .o_span  (w_cell[g])
        );
        assign w_valid_vec[g] = w_cell[g].valid;
    end

    csms_sweep #(
        .SPAN_SLOTS (SPAN_SLOTS)
    ) u_sweep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_sweep_go),
        .i_crit   (w_crit),
        .i_tail   (w_cell[SPAN_SLOTS-1]),
        .o_busy   (w_busy),
        .o_rotate (w_rotate),
        .o_res    (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_scan_en  <= 1'b1;
            r_warn_thr <= WARN_THR_RESET;
            r_crit_thr <= CRIT_THR_RESET;
        end else begin
            if (w_ctrl.clear) begin
                r_count <= '0;
            end else if (w_load_ok) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SCAN_EN:  r_scan_en  <= i_cfg_data[0];
                    CFG_WARN_THR: r_warn_thr <= i_cfg_data;
                    CFG_CRIT_THR: r_crit_thr <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_res.valid || w_load_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_full) begin
            r_kind  <= KIND_FULL;
            r_base  <= '0;
            r_bytes <= '0;
            r_objs  <= '0;
            r_last  <= 1'b1;
        end else begin
            r_kind  <= w_res.kind;
            r_base  <= w_res.base;
            r_bytes <= w_res.bytes;
            r_objs  <= w_res.objs;
            r_last  <= w_res.last;
        end
    end

    assign busy           = w_busy;
    assign o_cfg_ready    = 1'b1;
    assign o_strobe       = r_strobe;
    assign o_kind         = r_kind;
    assign o_leak_base    = r_base;
    assign o_leak_bytes   = r_bytes;
    assign o_leak_objects = r_objs;
    assign o_last         = r_last;

`ifndef NO_ASSERTIONS
    // table stays packed: occupied slots always match the entry count
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid_vec) == 32'(r_count))
        else $error("occupied slots disagree with entry count");

    a_rotate_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rotate |-> w_busy)
        else $error("chain rotating outside a sweep");

    a_sweep_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sweep_go |=> w_busy)
        else $error("sweep accepted but sequencer idle");

    a_full_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_full |-> !w_res.valid)
        else $error("table-full result collides with sweep output");
`endif

endmodule
